/* design/plucked_string_voice_defines.svh */
`ifndef PLUCKED_STRING_VOICE_DEFINES_SVH
`define PLUCKED_STRING_VOICE_DEFINES_SVH

// implication checked in the same cycle, disabled during reset
`define PSV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the next cycle, disabled during reset
`define PSV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/psv_pkg.sv */
package psv_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int OUT_W      = 17;
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int LEN_CFG_W  = 14;
    localparam int MODE_W     = 2;

    // operation codes
    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_GENERATE = 1'b1;

    // voice modes
    localparam logic [MODE_W-1:0] MODE_ORIGINAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TUNED    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MANDOLIN = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RING_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERP_WEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VOICE_MODE    = 3'd4;

    // register reset values
    localparam logic [LEN_CFG_W-1:0] RST_RING_LENGTH   = 14'd256;
    localparam logic [15:0]          RST_DECAY         = 16'd32768;
    localparam logic [15:0]          RST_INTERP_WEIGHT = 16'd0;
    localparam logic [15:0]          RST_AMPLITUDE     = 16'd32768;
    localparam logic [MODE_W-1:0]    RST_VOICE_MODE    = MODE_ORIGINAL;

    // filter weights in Q0.16: 0.1, 0.9 and the mandolin k
    localparam logic signed [16:0] K_TUNE_V = 17'sd6554;
    localparam logic signed [16:0] K_TUNE_P = 17'sd58982;
    localparam logic signed [16:0] K_MAND_V = 17'sd2731;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FETCH = 5'b00010,
        ST_MUL1  = 5'b00100,
        ST_MUL2  = 5'b01000,
        ST_WB    = 5'b10000
    } state_t;

    typedef struct packed {
        logic fetch;
        logic mul1;
        logic mul2;
    } ctrl_t;

endpackage

/* design/psv_mac.sv */
module psv_mac (
    input  logic                                  clk,
    input  psv_pkg::ctrl_t                        ctrl,
    input  logic [psv_pkg::MODE_W-1:0]            mode,
    input  logic signed [psv_pkg::SAMPLE_W-1:0]   ring_q,
    input  logic signed [psv_pkg::SAMPLE_W-1:0]   x,
    input  logic signed [psv_pkg::SAMPLE_W-1:0]   prev,
    input  logic [15:0]                           decay,
    input  logic [15:0]                           alpha,
    input  logic [15:0]                           amp,
    output logic signed [psv_pkg::SAMPLE_W-1:0]   v,
    output logic signed [psv_pkg::SAMPLE_W-1:0]   fb,
    output logic signed [psv_pkg::OUT_W-1:0]      vout
);
    import psv_pkg::*;

    logic tuned;
    logic mand;
    logic orig;

    logic signed [15:0] v_reg;
    logic signed [15:0] v_next;
    logic signed [16:0] vsum;

    logic signed [32:0] v33;
    logic signed [32:0] p33;
    logic signed [16:0] diff;
    logic signed [33:0] wdiff;
    logic signed [33:0] s_filt;
    logic signed [32:0] t_reg;
    logic signed [32:0] t_next;
    logic signed [32:0] s_reg;
    logic signed [32:0] s_next;

    logic signed [49:0] fp_reg;
    logic signed [49:0] fp_next;
    logic signed [49:0] op_reg;
    logic signed [49:0] op_next;
    logic               orig_reg;

    logic signed [49:0] fb_wide;
    logic signed [49:0] o_wide;

    assign tuned = (mode == MODE_TUNED);
    assign mand  = (mode == MODE_MANDOLIN);
    assign orig  = !(tuned || mand);

    // ring sample, with the mandolin addend saturated in
    assign vsum = 17'(ring_q) + 17'(x);
    always_comb
    begin
        if (!mand)
            v_next = ring_q;
        else if (vsum > 17'sd32767)
            v_next = 16'sh7fff;
        else if (vsum < -17'sd32768)
            v_next = 16'sh8000;
        else
            v_next = vsum[15:0];
    end

    // feedback weighted sum and interpolated output sample
    assign v33    = 33'(v_reg);
    assign p33    = 33'(prev);
    assign diff   = 17'(v_reg) - 17'(prev);
    assign wdiff  = 34'($signed({1'b0, alpha})) * 34'(diff);
    assign s_filt = 34'(p33 <<< 16) + wdiff;

    always_comb
    begin
        if (tuned)
            t_next = v33 * 33'(K_TUNE_V) + p33 * 33'(K_TUNE_P);
        else if (mand)
            t_next = v33 * 33'(K_MAND_V) + (p33 <<< 16);
        else
            t_next = v33 + p33;
    end

    assign s_next = orig ? (v33 <<< 16) : s_filt[32:0];

    assign fp_next = 50'(t_reg) * 50'($signed({1'b0, decay}));
    assign op_next = 50'(s_reg) * 50'($signed({1'b0, amp}));

    always_ff @(posedge clk)
    begin
        if (ctrl.fetch)
        begin
            v_reg <= v_next;
        end
        if (ctrl.mul1)
        begin
            t_reg <= t_next;
            s_reg <= s_next;
        end
        if (ctrl.mul2)
        begin
            fp_reg   <= fp_next;
            op_reg   <= op_next;
            orig_reg <= orig;
        end
    end

    // round to nearest, ties up, then saturate
    assign fb_wide = orig_reg ? ((fp_reg + 50'sd32768) >>> 16)
                              : ((fp_reg + 50'sd2147483648) >>> 32);
    assign o_wide  = (op_reg + 50'sd1073741824) >>> 31;

    always_comb
    begin
        if (fb_wide > 50'sd32767)
            fb = 16'sh7fff;
        else if (fb_wide < -50'sd32768)
            fb = 16'sh8000;
        else
            fb = fb_wide[15:0];

        if (o_wide > 50'sd65535)
            vout = 17'sh0ffff;
        else if (o_wide < -50'sd65536)
            vout = 17'sh10000;
        else
            vout = o_wide[16:0];
    end

    assign v = v_reg;

endmodule

/* design/plucked_string_voice.sv */
// channel   direction  tdata bits (low first)      tuser bits     tlast
// s_*       in         sample_in[15:0]             operation[0]   none
// m_*       out        voice_out[16:0], zero pad   none           none
// cfg_*     in         write enable, index, data   -              -
//
// a load beat writes the ring on accept; a generate beat runs through accept with
// the ring read, fetch of the registered ring word, two multiply stages, write back
// a new beat is accepted in the cycle after write back; one memory port serves all
// reset clears control, position, previous sample and registers; ring contents are
// undefined after reset and are not cleared
// write back waits while the output register is full and m_tready is low
module plucked_string_voice #(
    parameter int RING_DEPTH = 8192
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [psv_pkg::IN_DATA_W-1:0]      s_tdata,   // sample_in[15:0]
    input  logic [psv_pkg::IN_USER_W-1:0]      s_tuser,   // operation[0]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [psv_pkg::OUT_DATA_W-1:0]     m_tdata,   // voice_out[16:0]
    input  logic                               cfg_we,
    input  logic [psv_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [psv_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import psv_pkg::*;

    `include "plucked_string_voice_defines.svh"

    localparam int PW = $clog2(RING_DEPTH);
    localparam int LW = (PW + 1 > LEN_CFG_W) ? PW + 1 : LEN_CFG_W;
    localparam logic [LW-1:0] DEPTH_L = LW'(RING_DEPTH);
    localparam logic [LW-1:0] MIN_LEN = LW'(2);

    state_t state_reg;
    state_t state_next;

    logic [LEN_CFG_W-1:0] ring_length_reg;
    logic [15:0]          decay_reg;
    logic [15:0]          interp_weight_reg;
    logic [15:0]          amplitude_reg;
    logic [MODE_W-1:0]    voice_mode_reg;

    logic [PW-1:0]          ring_position_reg;
    logic [PW-1:0]          pos_reg;
    logic signed [15:0]     prev_reg;
    logic signed [15:0]     x_reg;
    logic                   out_valid_reg;
    logic signed [OUT_W-1:0] out_data_reg;

    logic signed [15:0] ring_mem [RING_DEPTH];
    logic signed [15:0] ring_q_reg;

    logic [LW-1:0] len;
    logic [LW-1:0] pos_wide;
    logic [PW-1:0] pos_eff;
    logic [LW-1:0] acc_inc;
    logic [PW-1:0] acc_pos_next;
    logic [LW-1:0] wb_inc;
    logic [PW-1:0] wb_pos_next;

    logic s_accept;
    logic m_accept;
    logic is_load;
    logic wb_go;

    logic          mem_we;
    logic          mem_re;
    logic [PW-1:0] mem_addr;
    logic signed [15:0] mem_wdata;

    ctrl_t              ctrl;
    logic signed [15:0] mac_v;
    logic signed [15:0] mac_fb;
    logic signed [OUT_W-1:0] mac_vout;

    // active length clamped to 2..RING_DEPTH
    always_comb
    begin
        if (LW'(ring_length_reg) < MIN_LEN)
            len = MIN_LEN;
        else if (LW'(ring_length_reg) > DEPTH_L)
            len = DEPTH_L;
        else
            len = LW'(ring_length_reg);
    end

    // a position left beyond a shortened ring restarts at zero
    assign pos_wide     = LW'(ring_position_reg);
    assign pos_eff      = (pos_wide < len) ? ring_position_reg : '0;
    assign acc_inc      = LW'(pos_eff) + LW'(1);
    assign acc_pos_next = (acc_inc >= len) ? '0 : acc_inc[PW-1:0];
    assign wb_inc       = LW'(pos_reg) + LW'(1);
    assign wb_pos_next  = (wb_inc >= len) ? '0 : wb_inc[PW-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;
    assign is_load  = (s_tuser[0] == OP_LOAD);
    assign wb_go    = (state_reg == ST_WB) && (!out_valid_reg || m_tready);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(unsigned'(out_data_reg));

    // single ring port: load writes on accept, generate reads on accept and writes at write back
    assign mem_we    = (s_accept && is_load) || wb_go;
    assign mem_re    = s_accept && !is_load;
    assign mem_addr  = (state_reg == ST_IDLE) ? pos_eff : pos_reg;
    assign mem_wdata = (state_reg == ST_IDLE) ? $signed(s_tdata) : mac_fb;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            ring_q_reg <= ring_mem[mem_addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept && !is_load)
                    state_next = ST_FETCH;
            end
            ST_FETCH: state_next = ST_MUL1;
            ST_MUL1:  state_next = ST_MUL2;
            ST_MUL2:  state_next = ST_WB;
            ST_WB:
            begin
                if (wb_go)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    assign ctrl.fetch = (state_reg == ST_FETCH);
    assign ctrl.mul1  = (state_reg == ST_MUL1);
    assign ctrl.mul2  = (state_reg == ST_MUL2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            ring_length_reg   <= RST_RING_LENGTH;
            decay_reg         <= RST_DECAY;
            interp_weight_reg <= RST_INTERP_WEIGHT;
            amplitude_reg     <= RST_AMPLITUDE;
            voice_mode_reg    <= RST_VOICE_MODE;
            ring_position_reg <= '0;
            prev_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RING_LENGTH:   ring_length_reg   <= cfg_data[LEN_CFG_W-1:0];
                    CFG_DECAY:         decay_reg         <= cfg_data;
                    CFG_INTERP_WEIGHT: interp_weight_reg <= cfg_data;
                    CFG_AMPLITUDE:     amplitude_reg     <= cfg_data;
                    CFG_VOICE_MODE:    voice_mode_reg    <= cfg_data[MODE_W-1:0];
                    default:           ;
                endcase
            end

            if (s_accept && is_load)
            begin
                ring_position_reg <= acc_pos_next;
                prev_reg          <= $signed(s_tdata);
            end
            else if (wb_go)
            begin
                ring_position_reg <= wb_pos_next;
                prev_reg          <= mac_v;
            end

            if (wb_go)
                out_valid_reg <= 1'b1;
            else if (m_accept)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            pos_reg <= pos_eff;
            x_reg   <= $signed(s_tdata);
        end
        if (wb_go)
        begin
            out_data_reg <= mac_vout;
        end
    end

    psv_mac u_mac (
        .clk    (clk),
        .ctrl   (ctrl),
        .mode   (voice_mode_reg),
        .ring_q (ring_q_reg),
        .x      (x_reg),
        .prev   (prev_reg),
        .decay  (decay_reg),
        .alpha  (interp_weight_reg),
        .amp    (amplitude_reg),
        .v      (mac_v),
        .fb     (mac_fb),
        .vout   (mac_vout)
    );

    `PSV_ASSERT_NOW(a_pos_in_ring, 1'b1, LW'(ring_position_reg) < DEPTH_L, "position outside ring")
    `PSV_ASSERT_NOW(a_port_single, 1'b1, !(mem_we && mem_re), "ring read and write collide")
    `PSV_ASSERT_NEXT(a_wb_hold, (state_reg == ST_WB) && out_valid_reg && !m_tready, (state_reg == ST_WB) && out_valid_reg, "result overwritten while stalled")
    `PSV_ASSERT_NEXT(a_load_quiet, s_accept && is_load && !out_valid_reg, !out_valid_reg, "load produced a result")

endmodule
